// File: hw/rtl/vtts_pkg.sv
// ============================================================================
// vtts_pkg: shared types and constants
// Constants, lane control struct and helpers for the vertex transform block.
// ============================================================================
package vtts_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int LANES          = 4;
    localparam int DIV_STEPS      = 32 + FRAC_BITS;  // quotient bits produced

    localparam logic [1:0] STAGE_CLIP   = 2'd0;
    localparam logic [1:0] STAGE_NDC    = 2'd1;
    localparam logic [1:0] STAGE_SCREEN = 2'd2;

    localparam logic [2:0] ADDR_ROW0   = 3'd0;
    localparam logic [2:0] ADDR_ROW1   = 3'd1;
    localparam logic [2:0] ADDR_ROW2   = 3'd2;
    localparam logic [2:0] ADDR_ROW3   = 3'd3;
    localparam logic [2:0] ADDR_WIDTH  = 3'd4;
    localparam logic [2:0] ADDR_HEIGHT = 3'd5;
    localparam logic [2:0] ADDR_STAGE  = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [1:0] stage;
        logic       sat;
    } vtts_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                                 output logic flag);
        begin
            flag = 1'b0;
            if (v > 64'sd2147483647)
            begin
                flag = 1'b1;
                sat32 = 32'sh7fffffff;
            end
            else if (v < -64'sd2147483648)
            begin
                flag = 1'b1;
                sat32 = 32'sh80000000;
            end
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

// File: hw/rtl/vertex_transform_to_screen.sv
// ============================================================================
// vertex_transform_to_screen: matrix, perspective divide, viewport
// Four matrix lanes, three divider lanes and a merging viewport stage.
// ============================================================================
// Accepts one vertex per clock while not stalled and returns one result per
// vertex in order. A vertex passes the product and clip registers of the
// matrix lanes, the pipelined divider stages, the viewport multiply register
// and the output register. The whole pipeline advances together, stalling
// when the output register is full and not taken.
module vertex_transform_to_screen
    import vtts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_x, in_y, in_z, in_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
    output logic [1:0]   m_tuser    // divide_skipped, saturated
);
    localparam int NS = DIV_STEPS + 5;  // valid stages before output

    logic [63:0] row_reg [4];
    logic [12:0] width_reg, height_reg;
    logic [1:0]  stage_reg;
    logic        adv;
    logic [NS-1:0] v_reg;
    logic [2:0]  ra;

    assign pready = 1'b1;
    assign ra = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= 64'd4096;
            row_reg[1] <= 64'd4096 << 16;
            row_reg[2] <= 64'd4096 << 32;
            row_reg[3] <= 64'd4096 << 48;
            width_reg  <= 13'd80;
            height_reg <= 13'd24;
            stage_reg  <= STAGE_SCREEN;
        end
        else if (psel && penable && pwrite)
        begin
            case (ra)
                ADDR_ROW0:   row_reg[0] <= pwdata;
                ADDR_ROW1:   row_reg[1] <= pwdata;
                ADDR_ROW2:   row_reg[2] <= pwdata;
                ADDR_ROW3:   row_reg[3] <= pwdata;
                ADDR_WIDTH:  width_reg  <= pwdata[12:0];
                ADDR_HEIGHT: height_reg <= pwdata[12:0];
                ADDR_STAGE:  stage_reg  <= pwdata[1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (ra)
            ADDR_ROW0:   prdata = row_reg[0];
            ADDR_ROW1:   prdata = row_reg[1];
            ADDR_ROW2:   prdata = row_reg[2];
            ADDR_ROW3:   prdata = row_reg[3];
            ADDR_WIDTH:  prdata = 64'(width_reg);
            ADDR_HEIGHT: prdata = 64'(height_reg);
            ADDR_STAGE:  prdata = 64'(stage_reg);
            default:     prdata = '0;
        endcase
    end

    // Pipeline advances when the output register is free or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], s_tvalid};
    end

    // Matrix lanes
    logic signed [31:0] clip [4];
    logic               lsat [4];
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        vtts_lane u_lane (
            .clk(clk), .en(adv), .row(row_reg[l]),
            .vx(s_tdata[31:0]), .vy(s_tdata[63:32]),
            .vz(s_tdata[95:64]), .vw(s_tdata[127:96]),
            .en2(adv), .clip(clip[l]), .sat(lsat[l]));
    end

    // Divider lanes plus a delay line for clip values and flags
    localparam int DL = DIV_STEPS + 1;
    logic signed [31:0] quo [3];
    logic               qsat [3];
    for (genvar l = 0; l < 3; l++)
    begin : g_div
        vtts_divider u_div (
            .clk(clk), .en({(DIV_STEPS+1){adv}}), .num(clip[l]),
            .den(clip[3]), .quo(quo[l]), .sat(qsat[l]));
    end

    logic signed [31:0] cd_reg [DL][4];
    logic               csat_reg [DL];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_reg[0]   <= clip;
            csat_reg[0] <= lsat[0] | lsat[1] | lsat[2] | lsat[3];
            for (int k = 1; k < DL; k++)
            begin
                cd_reg[k]   <= cd_reg[k-1];
                csat_reg[k] <= csat_reg[k-1];
            end
        end
    end

    // NDC merge and viewport multiply
    logic               skip, ndc_sat;
    logic signed [31:0] n [3];
    logic signed [31:0] cw;
    logic signed [63:0] sx_reg, sy_reg, sz_reg;
    logic signed [31:0] n_reg [3];
    logic signed [31:0] cw_reg;
    logic               skip_reg, sat1_reg;

    always_comb
    begin
        cw   = cd_reg[DL-1][3];
        skip = (stage_reg != STAGE_CLIP) && (cw == 32'sd0);
        ndc_sat = csat_reg[DL-1];
        for (int k = 0; k < 3; k++)
        begin
            if (stage_reg == STAGE_CLIP || skip)
                n[k] = cd_reg[DL-1][k];
            else
            begin
                n[k] = quo[k];
                ndc_sat = ndc_sat | qsat[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg    <= n;
            cw_reg   <= cw;
            skip_reg <= skip;
            sat1_reg <= ndc_sat;
            sx_reg   <= (64'(n[0]) + (64'sd1 <<< FRAC_BITS))
                        * $signed({51'd0, width_reg});
            sy_reg   <= ((64'sd1 <<< FRAC_BITS) - 64'(n[1]))
                        * $signed({51'd0, height_reg});
            sz_reg   <= 64'(n[2]) + (64'sd1 <<< FRAC_BITS);
        end
    end

    logic signed [31:0] rx, ry, rz;
    logic               f0, f1, f2, fs;
    always_comb
    begin
        rx = sat32(sx_reg >>> 1, f0);
        ry = sat32(sy_reg >>> 1, f1);
        rz = sat32(sz_reg >>> 1, f2);
        fs = sat1_reg;
        if (stage_reg == STAGE_CLIP || stage_reg == STAGE_NDC)
        begin
            rx = n_reg[0];
            ry = n_reg[1];
            rz = n_reg[2];
        end
        else
            fs = fs | f0 | f1 | f2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata <= {cw_reg, rz, ry, rx};
            m_tuser <= {fs, skip_reg};
        end
    end

    assign m_tvalid = v_reg[NS-1];
endmodule

// File: hw/rtl/vtts_lane.sv
// ============================================================================
// vtts_lane: one row of the matrix product
// Four products registered, then summed, rounded and saturated.
// ============================================================================
module vtts_lane
    import vtts_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [63:0]        row,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] vz,
    input  logic signed [31:0] vw,
    input  logic               en2,
    output logic signed [31:0] clip,
    output logic               sat
);
    logic signed [47:0] prod_reg [4];
    logic signed [49:0] acc;
    logic signed [63:0] shifted;
    logic signed [31:0] clip_reg;
    logic               sat_reg;
    logic               f;
    logic signed [31:0] c_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= $signed(row[15:0])  * vx;
            prod_reg[1] <= $signed(row[31:16]) * vy;
            prod_reg[2] <= $signed(row[47:32]) * vz;
            prod_reg[3] <= $signed(row[63:48]) * vw;
        end
    end

    always_comb
    begin
        acc = 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(prod_reg[2])
            + 50'(prod_reg[3]) + (50'sd1 <<< (COEF_FRAC_BITS - 1));
        shifted = 64'(acc >>> COEF_FRAC_BITS);
        c_s = sat32(shifted, f);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            clip_reg <= c_s;
            sat_reg  <= f;
        end
    end

    assign clip = clip_reg;
    assign sat  = sat_reg;
endmodule

// File: hw/rtl/vtts_divider.sv
// ============================================================================
// vtts_divider: pipelined signed divider
// One quotient bit per stage, truncating toward zero, with saturation.
// ============================================================================
module vtts_divider
    import vtts_pkg::*;
(
    input  logic               clk,
    input  logic [DIV_STEPS:0] en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo,
    output logic               sat
);
    localparam int NW = 32 + FRAC_BITS;

    logic [NW-1:0] rem_reg [DIV_STEPS+1];
    logic [NW-1:0] q_reg   [DIV_STEPS+1];
    logic [NW-1:0] d_reg   [DIV_STEPS+1];
    logic          neg_reg [DIV_STEPS+1];
    logic [NW-1:0] a_abs;
    logic [31:0]   d_abs;
    logic signed [31:0] q_s;
    logic          f;
    logic signed [63:0] q_full;

    always_comb
    begin
        a_abs = num[31] ? (NW'(~num) + NW'(1)) << FRAC_BITS
                        : NW'(num) << FRAC_BITS;
        d_abs = den[31] ? (~den + 32'd1) : den;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= a_abs;
            d_reg[0]   <= NW'(d_abs);
            neg_reg[0] <= num[31] ^ den[31];
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic [NW:0]   trial;
        logic [NW-1:0] r_sh;
        always_comb
        begin
            r_sh  = {rem_reg[s][NW-2:0], q_reg[s][NW-1]};
            trial = {1'b0, r_sh} - {1'b0, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en[s+1])
            begin
                rem_reg[s+1] <= trial[NW] ? r_sh : trial[NW-1:0];
                q_reg[s+1]   <= {q_reg[s][NW-2:0], ~trial[NW]};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    always_comb
    begin
        q_full = neg_reg[DIV_STEPS] ? -$signed({16'd0, q_reg[DIV_STEPS]})
                                    : $signed({16'd0, q_reg[DIV_STEPS]});
        q_s = sat32(q_full, f);
    end

    assign quo = q_s;
    assign sat = f;
endmodule

// File: hw/rtl/vtts_checker.sv
// ============================================================================
// vtts_checker: port-level checks
// Request handshake and output sanity on the top-level ports.
// ============================================================================
module vtts_checker
    import vtts_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tuser, m_tdata}))
        else $error("stalled request changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind vertex_transform_to_screen vtts_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready));
